// ===== hdl/csa_pkg.sv =====
// csa_pkg: operation and status codes for the checked signed ALU.
// No dependencies.
package csa_pkg;
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_REM = 3'd4
   } op_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;
endpackage

// ===== hdl/csa_if.sv =====
// csa_if: valid/ready channel carrying a payload of parameterized width.
// No dependencies.
interface csa_if #(parameter int W = 8) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/checked_signed_alu.sv =====
// checked_signed_alu: top level, add/sub/mul/div/rem with overflow status.
// Depends on csa_pkg and csa_if; the iterative divider csa_div is at the end of this file.
//
// A front end splits each beat and classifies it. It then writes the beat into a
// two-entry queue. While the queue has room, req.ready is high. The back end takes the
// head of the queue and writes the result into an output register, which holds while rsp
// is stalled. Add, subtract, multiply, unused selectors, divide by zero and the divide
// overflow case are computed directly from the queue head. While rsp is not stalled,
// those beats can follow back to back at one per cycle; each result passes through the
// queue and then the output register. Divide and remainder with a usable divisor go
// through a radix-2 restoring divider, which starts, iterates over the quotient bits and
// then hands over its result. Such a beat holds the back end until the divider hands
// over, and meanwhile the queue fills and req.ready drops. Multiply is a combinational
// DATA_WIDTH x DATA_WIDTH array.
module checked_signed_alu
   import csa_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic   clock,
   input  logic   reset,
   csa_if.sink    req,
   csa_if.source  rsp
);
   localparam int W  = DATA_WIDTH;
   localparam int QW = 2 * W + 4;   // action, a, b, divider flag
   localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

   // front: split the beat and classify it
   logic [2:0]   act;
   logic [W-1:0] a, b;
   logic         use_div;
   assign act     = req.data[2:0];
   assign a       = req.data[W+2:3];
   assign b       = req.data[2*W+2:W+3];
   assign use_div = (act == OP_DIV || act == OP_REM) && (b != '0) &&
                    !(act == OP_DIV && a == MIN_V && b == '1);

   // two-entry queue between front and back
   logic [QW-1:0] slot_ff [2];
   logic          wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          push, pop;
   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign wr_in     = push ? !wr_ff : wr_ff;
   assign rd_in     = pop ? !rd_ff : rd_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= {use_div, b, a, act};
      end
   end

   // back: head of the queue
   logic [QW-1:0] head;
   logic [2:0]    h_act;
   logic [W-1:0]  h_a, h_b;
   logic          h_div, h_vld;
   assign head  = slot_ff[rd_ff];
   assign h_act = head[2:0];
   assign h_a   = head[W+2:3];
   assign h_b   = head[2*W+2:W+3];
   assign h_div = head[2*W+3];
   assign h_vld = (cnt_ff != 2'd0);

   // operand magnitudes and the iterative divider
   logic [W-1:0] ma, mb, quo, rmd;
   logic         div_start, div_ack, div_busy, div_done, out_free;
   assign ma        = h_a[W-1] ? W'(-h_a) : h_a;
   assign mb        = h_b[W-1] ? W'(-h_b) : h_b;
   assign div_start = h_vld && h_div && !div_busy && !div_done;
   assign pop       = h_vld && out_free && (!h_div || div_done);
   assign div_ack   = pop && h_div;

   csa_div #(.W(W)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .ack     (div_ack),
      .dividend(ma),
      .divisor (mb),
      .busy    (div_busy),
      .done    (div_done),
      .quo     (quo),
      .rmd     (rmd)
   );

   // compute result and status for the head beat
   logic [W-1:0]          res;
   logic [1:0]            st;
   logic [W:0]            sum, dif;
   logic signed [2*W-1:0] prod;

   always_comb begin
      sum  = {h_a[W-1], h_a} + {h_b[W-1], h_b};
      dif  = {h_a[W-1], h_a} - {h_b[W-1], h_b};
      prod = $signed(h_a) * $signed(h_b);
      res  = '0;
      st   = ST_OK;
      case (h_act)
         OP_ADD: begin
            res = sum[W-1:0];
            if (sum[W] != sum[W-1]) st = ST_OVF;
         end
         OP_SUB: begin
            res = dif[W-1:0];
            if (dif[W] != dif[W-1]) st = ST_OVF;
         end
         OP_MUL: begin
            res = prod[W-1:0];
            if (prod[2*W-1:W-1] != {(W+1){prod[W-1]}}) st = ST_OVF;
         end
         OP_DIV: begin
            if (h_b == '0) st = ST_DIV0;
            else if (!h_div) st = ST_OVF;   // most negative over minus one
            else res = (h_a[W-1] ^ h_b[W-1]) ? W'(-quo) : quo;
         end
         OP_REM: begin
            if (h_b == '0) st = ST_DIV0;
            else res = h_a[W-1] ? W'(-rmd) : rmd;
         end
         default: res = '0;
      endcase
      if (st != ST_OK) res = '0;
   end

   // output register
   logic         vld_ff, vld_in;
   logic [W-1:0] res_ff;
   logic [1:0]   st_ff;
   assign out_free = !vld_ff || rsp.ready;
   assign vld_in   = pop ? 1'b1 : (vld_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (pop) begin
         res_ff <= res;
         st_ff  <= st;
      end
   end

   assign rsp.valid = vld_ff;
   assign rsp.data  = {st_ff, res_ff};

   // held result stays put while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed under stall");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && st_ff != ST_OK |-> res_ff == '0)
      else $error("nonzero result on error");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> cnt_ff != 2'd0)
      else $error("accepted beat missing from queue");
endmodule

// csa_div: radix-2 restoring divider on unsigned magnitudes, one quotient bit a cycle.
module csa_div #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         ack,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic         done,
   output logic [W-1:0] quo,
   output logic [W-1:0] rmd
);
   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  quo_ff, quo_in, rmd_ff, rmd_in, dvs_ff, dvs_in;
   logic [W:0]    shifted;
   logic [W-1:0]  trial;
   logic          fits;

   // one shift-and-subtract step per cycle
   always_comb begin
      shifted = {rmd_ff, quo_ff[W-1]};
      trial   = shifted[W-1:0] - dvs_ff;
      fits    = (shifted >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rmd_in  = rmd_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CW'(W);
         quo_in  = dividend;
         rmd_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[W-2:0], fits};
         rmd_in = fits ? trial : shifted[W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ack) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rmd_ff <= rmd_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;
   assign rmd  = rmd_ff;
endmodule

// ===== bench/checked_signed_alu_tb.sv =====
`timescale 1ns / 100ps
// checked_signed_alu_tb: self-checking bench for the checked signed ALU.
// Drives random and directed beats and compares every result with a predicted one.
// Depends on csa_pkg, csa_if and checked_signed_alu.
module checked_signed_alu_tb;
   import csa_pkg::*;

   localparam int DW       = 32;
   localparam int REQ_W    = 3 + 2 * DW;
   localparam int RSP_W    = DW + 2;
   localparam int WD_LIMIT = 4000;
   localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};

   typedef struct packed {
      logic [1:0]           status;
      logic signed [DW-1:0] value;
   } alu_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csa_if #(.W(REQ_W)) req_if (.clock(clock));
   csa_if #(.W(RSP_W)) rsp_if (.clock(clock));

   checked_signed_alu #(.DATA_WIDTH(DW)) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if.sink),
      .rsp  (rsp_if.source)
   );

   always #1 clock = ~clock;

   alu_result_t expected_results[$];
   int  error_count   = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_off_cycles = 0;
   int  quiet_cycles  = 0;
   bit  watchdog_on   = 1'b0;

   // Exact arithmetic at 64 bits, then range check at DW bits
   function automatic alu_result_t compute_checked(logic [2:0] action,
                                                   logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
      alu_result_t r;
      longint      exact;
      r.value  = '0;
      r.status = ST_OK;
      exact    = 0;
      case (action)
         OP_ADD: exact = longint'(a) + longint'(b);
         OP_SUB: exact = longint'(a) - longint'(b);
         OP_MUL: exact = longint'(a) * longint'(b);
         OP_DIV, OP_REM: begin
            if (b == 0) r.status = ST_DIV0;
            else if (action == OP_DIV) exact = longint'(a) / longint'(b);
            else exact = longint'(a) % longint'(b);
         end
         default: exact = 0;
      endcase
      if (r.status == ST_OK &&
          (exact > longint'(MAX_V) || exact < longint'(MIN_V)))
         r.status = ST_OVF;
      if (r.status == ST_OK) r.value = exact[DW-1:0];
      return r;
   endfunction

   // Send one beat; valid stays high after acceptance until the next gap
   task automatic send_beat(logic [2:0] action, logic signed [DW-1:0] a,
                            logic signed [DW-1:0] b);
      bit took;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= {b, a, action};
      do begin
         @(negedge clock);
         took = req_if.ready;
         @(posedge clock);
      end while (!took);
      expected_results.push_back(compute_checked(action, a, b));
   endtask

   task automatic park_sender();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DW-1:0] pick_operand();
      case ($urandom_range(5))
         0: return MIN_V + $urandom_range(3);
         1: return MAX_V - $urandom_range(3);
         2: return $signed($urandom_range(8)) - 4;
         3: return $signed($urandom_range(131071)) - 65536;
         default: return $urandom();
      endcase
   endfunction

   // Receiver: random stalls, plus a long hold-off counted here
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_if.ready    <= 1'b0;
      end else begin
         rsp_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // Result checker, sampled mid-cycle ahead of the accepting edge
   always @(negedge clock) begin
      alu_result_t got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat value=%0d status=%0d",
                     $time, got.value, got.status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.value !== want.value) begin
               $display("%0t: value mismatch expected %0d actual %0d",
                        $time, want.value, got.value);
               error_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status mismatch expected %0d actual %0d",
                        $time, want.status, got.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(negedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else if (watchdog_on)
         quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("checked_signed_alu test failed");
         $finish;
      end
   end

   task automatic test_directed();
      logic signed [DW-1:0] edges[6];
      edges = '{MIN_V, MAX_V, 0, 1, -1, 2};
      send_beat(OP_ADD, MAX_V, 1);
      send_beat(OP_ADD, MIN_V, -1);
      send_beat(OP_ADD, MIN_V, MAX_V);
      send_beat(OP_SUB, MIN_V, 1);
      send_beat(OP_SUB, 0, MIN_V);
      send_beat(OP_SUB, -1, MIN_V);
      send_beat(OP_MUL, MIN_V, -1);
      send_beat(OP_MUL, MIN_V, 1);
      send_beat(OP_MUL, 65536, 65536);
      send_beat(OP_MUL, -65536, 32768);
      send_beat(OP_MUL, 46341, -46341);
      send_beat(OP_DIV, 7, 0);
      send_beat(OP_REM, MIN_V, 0);
      // most negative over minus one: divide overflows, remainder is zero
      send_beat(OP_DIV, MIN_V, -1);
      send_beat(OP_REM, MIN_V, -1);
      send_beat(OP_DIV, -7, 2);
      send_beat(OP_REM, -7, 2);
      send_beat(OP_REM, 7, -2);
      send_beat(OP_DIV, MAX_V, MIN_V);
      // unused selectors give zero with ok status
      for (int k = 5; k < 8; k++) send_beat(k[2:0], edges[k-5], edges[k-4]);
      for (int k = 0; k < 5; k++) send_beat(k[2:0], edges[k], edges[5-k]);
      park_sender();
      wait_drained();
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++)
         send_beat(3'(($urandom_range(15) == 0) ? $urandom_range(7) : $urandom_range(4)),
                   pick_operand(), pick_operand());
      park_sender();
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // Long receiver hold-off while beats keep coming; input must stall
   task automatic test_backpressure();
      hold_off_cycles = 80;
      for (int n = 0; n < 40; n++)
         send_beat(3'($urandom_range(4)), pick_operand(), pick_operand());
      park_sender();
      wait_drained();
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      watchdog_on = 1'b1;
      test_directed();
      test_random(270, 0, 0);
      test_random(270, 72, 0);
      test_random(270, 0, 72);
      test_random(270, 13, 13);
      test_backpressure();
      watchdog_on = 1'b0;
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("checked_signed_alu test passed");
      else
         $display("checked_signed_alu test failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/csa_pkg.sv
hdl/csa_if.sv
hdl/checked_signed_alu.sv
bench/checked_signed_alu_tb.sv
